### rtl/core/gpc_pkg.sv
// gpc_pkg: shared types and constants of the gateway packet classifier
// no dependencies; imported by gpc_classify, gpc_out_buf, gateway_packet_classifier and the test bench
`default_nettype none

package gpc_pkg;

  // packet framing constants
  localparam logic [31:0] GatewayMagic = 32'h4453_5250;
  localparam logic [7:0]  TypeText     = 8'h00;
  localparam logic [7:0]  TypeTempText = 8'h01;
  localparam logic [7:0]  TypeStatus   = 8'h04;
  localparam logic [7:0]  TypeHeader   = 8'h20;
  localparam logic [7:0]  TypeData     = 8'h21;
  localparam logic [7:0]  StatusMax    = 8'h04;
  localparam logic [7:0]  EndBit       = 8'h40;
  localparam logic [15:0] CheckSkip    = 16'hFFFF;
  localparam logic [23:0] SyncTriple   = 24'h552D16;
  localparam logic [23:0] MaskTriple   = 24'h704F93;
  localparam logic [7:0]  HeaderRoom   = 8'd9;
  localparam logic [7:0]  LimitReset   = 8'd246;
  localparam logic [15:0] NoStream     = 16'h0000;

  // result classes
  typedef enum logic [2:0] {
    ClsIgnored  = 3'd0,
    ClsText     = 3'd1,
    ClsTempText = 3'd2,
    ClsStatus   = 3'd3,
    ClsHeader   = 3'd4,
    ClsData     = 3'd5
  } gpc_class_t;

  // one result transaction
  typedef struct packed {
    gpc_class_t  pkt_class;
    logic [2:0]  status_index;
    logic [15:0] stream_id;
    logic [7:0]  sequence_res;
    logic        last_in_stream;
    logic [23:0] slow_out;
    logic [7:0]  payload_length;
    logic        checksum_bypass;
  } gpc_result_t;

  // update of the locked stream register
  typedef struct packed {
    logic        we;
    logic [15:0] value;
  } gpc_lock_upd_t;

endpackage

`default_nettype wire

### rtl/core/gpc_classify.sv
// gpc_classify: combinational decode of one packet descriptor into a result
// depends on gpc_pkg; also produces the update of the locked stream id
`default_nettype none

module gpc_classify
  import gpc_pkg::*;
(
  input  wire logic          command,
  input  wire logic          from_gateway,
  input  wire logic [7:0]    packet_length,
  input  wire logic [31:0]   magic_word,
  input  wire logic [7:0]    packet_type,
  input  wire logic [7:0]    byte_five,
  input  wire logic [7:0]    byte_six,
  input  wire logic [7:0]    byte_seven,
  input  wire logic [15:0]   check_word,
  input  wire logic [23:0]   slow_bytes,
  input  wire logic [15:0]   locked_stream,
  input  wire logic [7:0]    payload_limit,
  output gpc_result_t        result,
  output gpc_lock_upd_t      lock_upd
);

  logic [15:0] id;
  logic        frame_ok;
  logic        is_end;
  logic [23:0] slow_fix;
  logic [7:0]  plen_raw;
  logic [7:0]  plen_cap;

  assign id       = {byte_five, byte_six};
  assign frame_ok = from_gateway && (packet_length != 8'd0) && (magic_word == GatewayMagic);
  assign is_end   = (byte_seven & EndBit) != 8'd0;

  // sync regeneration on sequence zero, sync masking elsewhere
  always_comb begin
    if (byte_seven == 8'd0) begin
      slow_fix = SyncTriple;
    end else if (slow_bytes == SyncTriple) begin
      slow_fix = MaskTriple;
    end else begin
      slow_fix = slow_bytes;
    end
  end

  // payload length: strip header room, saturate, cap by limit
  assign plen_raw = (packet_length > HeaderRoom) ? (packet_length - HeaderRoom) : 8'd0;
  assign plen_cap = (plen_raw > payload_limit) ? payload_limit : plen_raw;

  // classification and lock update
  always_comb begin
    result   = '0;
    lock_upd = '0;
    if (command) begin
      lock_upd.we    = 1'b1;
      lock_upd.value = NoStream;
    end else if (frame_ok) begin
      case (packet_type)
        TypeText: begin
          result.pkt_class = ClsText;
        end
        TypeTempText: begin
          result.pkt_class = ClsTempText;
        end
        TypeStatus: begin
          if (byte_five <= StatusMax) begin
            result.pkt_class    = ClsStatus;
            result.status_index = byte_five[2:0];
          end
        end
        TypeHeader: begin
          if (locked_stream == NoStream) begin
            lock_upd.we            = 1'b1;
            lock_upd.value         = id;
            result.pkt_class       = ClsHeader;
            result.stream_id       = id;
            result.checksum_bypass = (check_word == CheckSkip);
          end
        end
        TypeData: begin
          if (id == locked_stream) begin
            if (is_end) begin
              lock_upd.we    = 1'b1;
              lock_upd.value = NoStream;
            end
            result.pkt_class      = ClsData;
            result.stream_id      = id;
            result.sequence_res   = byte_seven;
            result.last_in_stream = is_end;
            result.slow_out       = slow_fix;
            result.payload_length = plen_cap;
          end
        end
        default: begin
          result.pkt_class = ClsIgnored;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/gpc_out_buf.sv
// gpc_out_buf: two-entry result register with skid stage
// depends on gpc_pkg for the result struct
`default_nettype none

module gpc_out_buf
  import gpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire gpc_result_t push_data,
  output logic             full,
  output logic             head_valid,
  output gpc_result_t      head_data,
  input  wire logic        head_stall
);

  logic        head_valid_r;
  logic        skid_valid_r;
  gpc_result_t head_r;
  gpc_result_t skid_r;
  logic        pop;

  assign pop        = head_valid_r && !head_stall;
  assign full       = skid_valid_r;
  assign head_valid = head_valid_r;
  assign head_data  = head_r;

  // control: head and skid occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      if (head_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        head_valid_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        head_r <= skid_r;
      end else if (push) begin
        head_r <= push_data;
      end
    end else if (push) begin
      if (head_valid_r) begin
        skid_r <= push_data;
      end else begin
        head_r <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/gateway_packet_classifier.sv
// gateway_packet_classifier: top level of the gateway packet classifier
// depends on gpc_pkg, gpc_classify and gpc_out_buf
//
// Usage:
//   Input channel (in_valid / in_stall): one packet descriptor per transaction,
//   or a clear command (in_command high) that frees the locked stream.
//   Result channel (out_valid / out_stall): exactly one result transaction per
//   input transaction, in order.
//   Configuration channel (cfg_valid / cfg_ready): writes payload_limit; ready
//   is always high. Write only while the block is idle.
// Result path and throughput:
//   A result is registered in the result buffer when its input is accepted.
//   One transaction per cycle is sustained while out_stall is low; decode and
//   lock update are combinational logic in front of the result register.
// Stall behavior:
//   A two-entry result buffer lets one more transaction in while a result
//   waits; in_stall rises only when the skid entry is occupied.
// Reset:
//   Synchronous, active low. Clears the locked stream, loads payload_limit
//   with 246 and empties the result buffer.
`default_nettype none

module gateway_packet_classifier
  import gpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transactions
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic        in_from_gateway,
  input  wire logic [7:0]  in_packet_length,
  input  wire logic [31:0] in_magic_word,
  input  wire logic [7:0]  in_packet_type,
  input  wire logic [7:0]  in_byte_five,
  input  wire logic [7:0]  in_byte_six,
  input  wire logic [7:0]  in_byte_seven,
  input  wire logic [15:0] in_check_word,
  input  wire logic [23:0] in_slow_bytes,
  // result transactions
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_packet_class,
  output logic [2:0]       out_status_index,
  output logic [15:0]      out_stream_id,
  output logic [7:0]       out_sequence_res,
  output logic             out_last_in_stream,
  output logic [23:0]      out_slow_out,
  output logic [7:0]       out_payload_length,
  output logic             out_checksum_bypass,
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_payload_limit
);

  logic [15:0]   lock_r;
  logic [7:0]    limit_r;
  logic          in_acc;
  logic          buf_full;
  gpc_result_t   res;
  gpc_result_t   head;
  gpc_lock_upd_t lock_upd;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_acc    = in_valid && !buf_full;

  // descriptor decode
  gpc_classify u_classify (
    .command       (in_command),
    .from_gateway  (in_from_gateway),
    .packet_length (in_packet_length),
    .magic_word    (in_magic_word),
    .packet_type   (in_packet_type),
    .byte_five     (in_byte_five),
    .byte_six      (in_byte_six),
    .byte_seven    (in_byte_seven),
    .check_word    (in_check_word),
    .slow_bytes    (in_slow_bytes),
    .locked_stream (lock_r),
    .payload_limit (limit_r),
    .result        (res),
    .lock_upd      (lock_upd)
  );

  // locked stream and payload limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r  <= NoStream;
      limit_r <= LimitReset;
    end else begin
      if (in_acc && lock_upd.we) begin
        lock_r <= lock_upd.value;
      end
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_payload_limit;
      end
    end
  end

  // result buffer
  gpc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc),
    .push_data  (res),
    .full       (buf_full),
    .head_valid (out_valid),
    .head_data  (head),
    .head_stall (out_stall)
  );

  assign out_packet_class    = head.pkt_class;
  assign out_status_index    = head.status_index;
  assign out_stream_id       = head.stream_id;
  assign out_sequence_res    = head.sequence_res;
  assign out_last_in_stream  = head.last_in_stream;
  assign out_slow_out        = head.slow_out;
  assign out_payload_length  = head.payload_length;
  assign out_checksum_bypass = head.checksum_bypass;

  // clear command frees the lock
  a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_command) |=> (lock_r == NoStream))
    else $error("lock not freed after clear command");

  // end of stream frees the lock
  a_end_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.pkt_class == ClsData && res.last_in_stream) |=> (lock_r == NoStream))
    else $error("lock not freed after last data packet");

  // a header is only taken while no stream is locked
  a_header_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.pkt_class == ClsHeader) |-> (lock_r == NoStream))
    else $error("header accepted while a stream is locked");

  // skid entry is only used behind a waiting head
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid entry occupied with empty head");

endmodule

`default_nettype wire

### sim/gateway_packet_classifier_test.sv
// gateway_packet_classifier_test: self-checking bench for the gateway packet classifier
// predicts each result from its own model of the stream lock and payload limit
// depends on gpc_pkg and gateway_packet_classifier
`timescale 1ns / 100ps

module gateway_packet_classifier_test
  import gpc_pkg::*;
;

  // one input transaction, field by field
  typedef struct packed {
    logic        command;
    logic        from_gateway;
    logic [7:0]  packet_length;
    logic [31:0] magic_word;
    logic [7:0]  packet_type;
    logic [7:0]  byte_five;
    logic [7:0]  byte_six;
    logic [7:0]  byte_seven;
    logic [15:0] check_word;
    logic [23:0] slow_bytes;
  } pkt_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pkt_t        on_wire;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_packet_class;
  logic [2:0]  out_status_index;
  logic [15:0] out_stream_id;
  logic [7:0]  out_sequence_res;
  logic        out_last_in_stream;
  logic [23:0] out_slow_out;
  logic [7:0]  out_payload_length;
  logic        out_checksum_bypass;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_payload_limit;

  // bench state
  pkt_t        pending_pkts[$];
  gpc_result_t due_results[$];
  logic [15:0] held_stream;
  logic [7:0]  limit_now;
  logic [15:0] last_stream_id;
  logic        in_took;
  logic        steady;
  int          in_gap;
  int          out_gap;
  int          queued_count;
  int          taken_count;
  int          results_seen;
  int          mismatches;

  gateway_packet_classifier DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (on_wire.command),
    .in_from_gateway     (on_wire.from_gateway),
    .in_packet_length    (on_wire.packet_length),
    .in_magic_word       (on_wire.magic_word),
    .in_packet_type      (on_wire.packet_type),
    .in_byte_five        (on_wire.byte_five),
    .in_byte_six         (on_wire.byte_six),
    .in_byte_seven       (on_wire.byte_seven),
    .in_check_word       (on_wire.check_word),
    .in_slow_bytes       (on_wire.slow_bytes),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_packet_class    (out_packet_class),
    .out_status_index    (out_status_index),
    .out_stream_id       (out_stream_id),
    .out_sequence_res    (out_sequence_res),
    .out_last_in_stream  (out_last_in_stream),
    .out_slow_out        (out_slow_out),
    .out_payload_length  (out_payload_length),
    .out_checksum_bypass (out_checksum_bypass),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_payload_limit   (cfg_payload_limit)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // predicted result of one packet; updates the stream lock
  function automatic gpc_result_t classify_packet(pkt_t p);
    gpc_result_t r;
    logic [15:0] id;
    logic [7:0]  room;
    r  = '0;
    id = {p.byte_five, p.byte_six};
    if (p.command) begin
      held_stream = NoStream;
      return r;
    end
    if (!p.from_gateway || p.packet_length == 8'd0 || p.magic_word != GatewayMagic)
      return r;
    case (p.packet_type)
      TypeText:     r.pkt_class = ClsText;
      TypeTempText: r.pkt_class = ClsTempText;
      TypeStatus: begin
        if (p.byte_five <= StatusMax) begin
          r.pkt_class    = ClsStatus;
          r.status_index = p.byte_five[2:0];
        end
      end
      TypeHeader: begin
        if (held_stream == NoStream) begin
          held_stream       = id;
          r.pkt_class       = ClsHeader;
          r.stream_id       = id;
          r.checksum_bypass = (p.check_word == CheckSkip);
        end
      end
      TypeData: begin
        if (id == held_stream) begin
          if ((p.byte_seven & EndBit) != 8'd0)
            held_stream = NoStream;
          // sync regeneration on sequence zero, masking of stray sync elsewhere
          if (p.byte_seven == 8'd0)
            r.slow_out = SyncTriple;
          else if (p.slow_bytes == SyncTriple)
            r.slow_out = MaskTriple;
          else
            r.slow_out = p.slow_bytes;
          room = (p.packet_length > HeaderRoom) ? p.packet_length - HeaderRoom : 8'd0;
          if (room > limit_now)
            room = limit_now;
          r.pkt_class      = ClsData;
          r.stream_id      = id;
          r.sequence_res   = p.byte_seven;
          r.last_in_stream = ((p.byte_seven & EndBit) != 8'd0);
          r.payload_length = room;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("error: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [31:0] seen, logic [31:0] wanted);
    if (seen !== wanted)
      note_mismatch($sformatf("result %0d %s: got %h expected %h",
                              results_seen, name, seen, wanted));
  endtask

  // fully random transaction
  function automatic pkt_t random_packet();
    pkt_t p;
    p.command       = 1'($urandom_range(0, 1));
    p.from_gateway  = 1'($urandom_range(0, 1));
    p.packet_length = 8'($urandom_range(0, 255));
    p.magic_word    = $urandom;
    p.packet_type   = 8'($urandom_range(0, 255));
    p.byte_five     = 8'($urandom_range(0, 255));
    p.byte_six      = 8'($urandom_range(0, 255));
    p.byte_seven    = 8'($urandom_range(0, 255));
    p.check_word    = 16'($urandom_range(0, 65535));
    p.slow_bytes    = 24'($urandom);
    return p;
  endfunction

  // well-formed packet from the gateway with random content
  function automatic pkt_t framed_packet(logic [7:0] kind);
    pkt_t p;
    p               = random_packet();
    p.command       = 1'b0;
    p.from_gateway  = 1'b1;
    p.packet_length = 8'($urandom_range(1, 255));
    p.magic_word    = GatewayMagic;
    p.packet_type   = kind;
    return p;
  endfunction

  task automatic enqueue_packet(pkt_t p);
    pending_pkts.push_back(p);
    queued_count++;
  endtask

  // header, a run of data packets, maybe an end bit, maybe intruders, maybe a clear
  task automatic queue_stream();
    pkt_t        p;
    logic [15:0] id;
    int          n;
    logic        ends;
    id = ($urandom_range(0, 7) == 0) ? NoStream : 16'($urandom);
    last_stream_id = id;
    p = framed_packet(TypeHeader);
    {p.byte_five, p.byte_six} = id;
    if ($urandom_range(0, 1) == 0)
      p.check_word = CheckSkip;
    enqueue_packet(p);
    n    = $urandom_range(1, 6);
    ends = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) begin
      p = framed_packet(TypeData);
      {p.byte_five, p.byte_six} = id;
      p.byte_seven = 8'(i);
      if ($urandom_range(0, 7) == 0)
        p.byte_seven = p.byte_seven | 8'h80;
      if ($urandom_range(0, 3) == 0)
        p.slow_bytes = SyncTriple;
      if ($urandom_range(0, 2) == 0)
        p.packet_length = 8'($urandom_range(0, 12));
      if (ends && i == n - 1)
        p.byte_seven = p.byte_seven | EndBit;
      enqueue_packet(p);
      // foreign header or data in the middle of a stream
      if ($urandom_range(0, 9) == 0)
        enqueue_packet(framed_packet(($urandom_range(0, 1) == 0) ? TypeHeader : TypeData));
    end
    if (!ends && $urandom_range(0, 1) == 0) begin
      p = random_packet();
      p.command = 1'b1;
      enqueue_packet(p);
    end
  endtask

  // streams mixed with single packets and noise
  task automatic queue_mixed(int n);
    pkt_t p;
    int   goal;
    goal = queued_count + n;
    while (queued_count < goal) begin
      if ($urandom_range(0, 9) < 5) begin
        queue_stream();
      end else begin
        case ($urandom_range(0, 13))
          0: begin
            p = random_packet();
            p.command = 1'b1;
          end
          1: p = random_packet();
          2: begin
            p = framed_packet(TypeStatus);
            p.from_gateway = 1'b0;
          end
          3: begin
            p = framed_packet(TypeHeader);
            p.packet_length = 8'd0;
          end
          4: begin
            p = framed_packet(TypeData);
            p.magic_word = p.magic_word ^ (32'd1 << $urandom_range(0, 31));
          end
          5: p = framed_packet(TypeText);
          6: p = framed_packet(TypeTempText);
          7: begin
            p = framed_packet(TypeStatus);
            p.byte_five = 8'($urandom_range(0, 7));
          end
          8: begin
            p = framed_packet(TypeHeader);
            if ($urandom_range(0, 1) == 0)
              p.check_word = CheckSkip;
          end
          9: begin
            p = framed_packet(TypeData);
            {p.byte_five, p.byte_six} = last_stream_id;
          end
          10: begin
            p = framed_packet(TypeData);
            {p.byte_five, p.byte_six} = NoStream;
            if ($urandom_range(0, 1) == 0)
              p.byte_seven = 8'd0;
          end
          11: p = framed_packet(8'($urandom_range(0, 255)));
          12: begin
            p = framed_packet(TypeHeader);
            {p.byte_five, p.byte_six} = NoStream;
          end
          default: begin
            p = framed_packet(TypeData);
            if ($urandom_range(0, 1) == 0)
              p.slow_bytes = SyncTriple;
          end
        endcase
        enqueue_packet(p);
      end
    end
  endtask

  // block until every queued transaction is taken and answered
  task automatic wait_quiet();
    while (!(taken_count == queued_count && due_results.size() == 0))
      @(negedge clk);
  endtask

  // register write while the block is idle
  task automatic set_payload_limit(logic [7:0] v);
    repeat (4) @(negedge clk);
    cfg_payload_limit <= v;
    cfg_valid         <= 1'b1;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver: holds a stalled transaction, otherwise idles or sends the next one
  always @(negedge clk) begin : feed
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 13);
      end else if (pending_pkts.size() != 0) begin
        in_valid <= 1'b1;
        on_wire  <= pending_pkts.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall bursts
  always @(negedge clk) begin : backpressure
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap   <= out_gap - 1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_gap   <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results, then predict for the input taken at this edge
  always @(posedge clk) begin : watch
    gpc_result_t want;
    in_took <= in_valid && !in_stall;
    if (!rst_n) begin
      held_stream = NoStream;
      limit_now   = LimitReset;
    end else begin
      if (cfg_valid && cfg_ready)
        limit_now = cfg_payload_limit;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = due_results.pop_front();
          compare_field("packet_class", out_packet_class, want.pkt_class);
          compare_field("status_index", out_status_index, want.status_index);
          compare_field("stream_id", out_stream_id, want.stream_id);
          compare_field("sequence_res", out_sequence_res, want.sequence_res);
          compare_field("last_in_stream", out_last_in_stream, want.last_in_stream);
          compare_field("slow_out", out_slow_out, want.slow_out);
          compare_field("payload_length", out_payload_length, want.payload_length);
          compare_field("checksum_bypass", out_checksum_bypass, want.checksum_bypass);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(classify_packet(on_wire));
        taken_count++;
      end
    end
  end

  // main sequence
  initial begin : run
    pkt_t p;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    on_wire           = '0;
    out_stall         = 1'b0;
    cfg_valid         = 1'b0;
    cfg_payload_limit = 8'd0;
    in_took           = 1'b0;
    steady            = 1'b0;
    in_gap            = 0;
    out_gap           = 0;
    queued_count      = 0;
    taken_count       = 0;
    results_seen      = 0;
    mismatches        = 0;
    held_stream       = NoStream;
    limit_now         = LimitReset;
    last_stream_id    = NoStream;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: commands, rejects, every type, lock rules, sync handling, limit
    p = random_packet();
    p.command = 1'b1;
    enqueue_packet(p);
    p = framed_packet(TypeStatus);
    p.from_gateway = 1'b0;
    enqueue_packet(p);
    p = framed_packet(TypeText);
    p.packet_length = 8'd0;
    enqueue_packet(p);
    p = framed_packet(TypeText);
    p.magic_word = ~GatewayMagic;
    enqueue_packet(p);
    enqueue_packet(framed_packet(TypeText));
    enqueue_packet(framed_packet(TypeTempText));
    p = framed_packet(TypeStatus);
    p.byte_five = 8'd0;
    enqueue_packet(p);
    p = framed_packet(TypeStatus);
    p.byte_five = StatusMax;
    enqueue_packet(p);
    p = framed_packet(TypeStatus);
    p.byte_five = StatusMax + 8'd1;
    enqueue_packet(p);
    enqueue_packet(framed_packet(8'hFF));
    // header with id zero leaves the lock free
    p = framed_packet(TypeHeader);
    {p.byte_five, p.byte_six} = NoStream;
    p.check_word = CheckSkip;
    enqueue_packet(p);
    // data with id zero passes while unlocked, sequence zero regenerates sync
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = NoStream;
    p.byte_seven    = 8'd0;
    p.packet_length = 8'd255;
    enqueue_packet(p);
    p = framed_packet(TypeHeader);
    {p.byte_five, p.byte_six} = 16'hABCD;
    p.check_word = 16'h1234;
    enqueue_packet(p);
    // header while locked and data of another stream are ignored
    p = framed_packet(TypeHeader);
    {p.byte_five, p.byte_six} = 16'h1111;
    enqueue_packet(p);
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = 16'h1111;
    enqueue_packet(p);
    // stray sync masked, short packets
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = 16'hABCD;
    p.byte_seven    = 8'd1;
    p.slow_bytes    = SyncTriple;
    p.packet_length = HeaderRoom;
    enqueue_packet(p);
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = 16'hABCD;
    p.byte_seven    = 8'd2;
    p.packet_length = 8'd3;
    enqueue_packet(p);
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = 16'hABCD;
    p.byte_seven    = EndBit | 8'd5;
    p.packet_length = HeaderRoom + 8'd1;
    enqueue_packet(p);
    p = framed_packet(TypeHeader);
    {p.byte_five, p.byte_six} = 16'hFFFF;
    p.check_word = CheckSkip;
    enqueue_packet(p);
    // clear command frees the lock
    p = random_packet();
    p.command = 1'b1;
    enqueue_packet(p);
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = 16'hFFFF;
    enqueue_packet(p);
    p = framed_packet(TypeHeader);
    {p.byte_five, p.byte_six} = 16'h8000;
    enqueue_packet(p);
    p = framed_packet(TypeData);
    {p.byte_five, p.byte_six} = 16'h8000;
    p.byte_seven = 8'hFF;
    p.slow_bytes = SyncTriple;
    enqueue_packet(p);
    wait_quiet();

    // random phases across limit settings, extremes included
    set_payload_limit(8'd0);
    queue_mixed(110);
    wait_quiet();
    set_payload_limit(LimitReset);
    queue_mixed(110);
    wait_quiet();
    set_payload_limit(8'($urandom_range(1, 245)));
    queue_mixed(110);
    wait_quiet();
    // last phase runs without idling on either side
    steady = 1'b1;
    set_payload_limit(8'($urandom_range(0, 246)));
    queue_mixed(100);
    wait_quiet();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("gateway_packet_classifier: match");
    end else begin
      $display("gateway_packet_classifier: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #2_000_000;
    $display("gateway_packet_classifier: mismatch");
    $finish;
  end

endmodule

### files.f
rtl/core/gpc_pkg.sv
rtl/core/gpc_classify.sv
rtl/core/gpc_out_buf.sv
rtl/core/gateway_packet_classifier.sv
sim/gateway_packet_classifier_test.sv
